// ===== hdl/ctfc_pkg.sv =====
// Shared types and constants for the clock tree frequency calculator.
package ctfc_pkg;

   localparam int HZ_W   = 32;
   localparam int BASE_W = 26;
   localparam int M_W    = 6;
   localparam int N_W    = 9;
   localparam int PROD_W = BASE_W + N_W;
   localparam int SCALED_W = PROD_W - 1;

   localparam logic [BASE_W-1:0] HSI_HZ    = BASE_W'(16000000);
   localparam logic [BASE_W-1:0] HSE_RESET = BASE_W'(25000000);

   localparam logic [1:0] SRC_INTERNAL = 2'd0;
   localparam logic [1:0] SRC_EXTERNAL = 2'd1;
   localparam logic [1:0] SRC_PLL      = 2'd2;
   localparam logic [1:0] SRC_INVALID  = 2'd3;

   localparam logic [1:0] P_DIV2 = 2'd0;
   localparam logic [1:0] P_DIV4 = 2'd1;
   localparam logic [1:0] P_DIV6 = 2'd2;
   localparam logic [1:0] P_DIV8 = 2'd3;

   // divide by 3 as x * ceil(2^35 / 3) >> 35, exact for x below 2^34;
   // x is split in two halves so each partial product stays narrow
   localparam int RECIP3_W    = 34;
   localparam int RECIP3_SH   = 35;
   localparam logic [RECIP3_W-1:0] RECIP3 = 34'd11453246123;
   localparam int DIV3_SPLIT  = SCALED_W / 2;
   localparam int DIV3_HI_W   = SCALED_W - DIV3_SPLIT;
   localparam int PP_W        = DIV3_HI_W + RECIP3_W;
   localparam int DIV3_PROD_W = SCALED_W + RECIP3_W;

   // queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // back pipeline layout
   localparam int M_STEPS      = 4;
   localparam int M_DIV_STAGES = (BASE_W + M_STEPS - 1) / M_STEPS;
   localparam int MUL_IDX      = M_DIV_STAGES + 1;
   localparam int SHIFT_IDX    = MUL_IDX + 1;
   localparam int DIV3_MUL_IDX = SHIFT_IDX + 1;
   localparam int DIV3_SUM_IDX = DIV3_MUL_IDX + 1;
   localparam int SYS_IDX      = DIV3_SUM_IDX + 1;
   localparam int NUM_STAGES   = SYS_IDX + 1;

   typedef struct packed {
      logic [1:0]     clock_source;
      logic           pll_source;
      logic [M_W-1:0] pll_m;
      logic [N_W-1:0] pll_n;
      logic [1:0]     pll_p_code;
      logic [3:0]     ahb_code;
      logic [2:0]     apb1_code;
      logic [2:0]     apb2_code;
   } req_type;

   typedef struct packed {
      logic [HZ_W-1:0] sysclk_hz;
      logic [HZ_W-1:0] ahb_hz;
      logic [HZ_W-1:0] apb1_hz;
      logic [HZ_W-1:0] apb1_timer_hz;
      logic [HZ_W-1:0] apb2_hz;
      logic [HZ_W-1:0] apb2_timer_hz;
      logic            bad_setting;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic              is_pll;
      logic              bad_m;
      logic [BASE_W-1:0] fixed_hz;
      logic [BASE_W-1:0] base_hz;
      logic [M_W-1:0]    m;
      logic [N_W-1:0]    n;
      logic [1:0]        p_code;
      logic [3:0]        ahb_sh;
      logic [2:0]        apb1_bus_sh;
      logic [1:0]        apb1_tmr_sh;
      logic [2:0]        apb2_bus_sh;
      logic [1:0]        apb2_tmr_sh;
   } cls_type;

endpackage

// ===== hdl/clock_tree_frequency_calc_top.sv =====
// Top level of the clock tree frequency calculator.
//
// Usage:
//  - req_*: one clock configuration snapshot per request (source select, PLL
//    M/N/P, AHB and APB prescaler codes). Accepted when req_valid && !req_stall.
//  - rsp_*: one response per request, in order: sysclk, AHB, both APB and
//    both timer clocks in Hz, plus bad_setting (PLL with M of zero, or a PLL
//    result that saturated at 32 bits). Taken when rsp_valid && !rsp_stall.
//  - csr_*: csr_wr_en writes the 26-bit external oscillator frequency; write
//    it only while no request is in flight. Reset value is 25 MHz.
// Throughput: one request per cycle, sustained while rsp_stall is low.
// Pipeline: front register, queue, input stage, 7 stages of 4-bit base/M
//  division, a multiply, a P shift, 2 stages of reciprocal divide-by-3,
//  saturation/AHB, output reg.
// Stall: a stalled response freezes the back pipeline; the queue between
//  front and back keeps taking requests until it and the front register
//  fill, then req_stall rises.
// Reset (synchronous): empties the front register, queue and pipeline and
//  restores the oscillator register.
module clock_tree_frequency_calc_top import ctfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [BASE_W-1:0] csr_wr_data
);

   logic    push_valid;
   cls_type push_data;
   logic    queue_full;
   logic    pop_valid;
   cls_type pop_data;
   logic    pop_en;

   ctfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .queue_full  (queue_full)
   );

   ctfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_en     (pop_en)
   );

   ctfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_data   (pop_data),
      .in_pop    (pop_en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // flagged result is either forced zero or saturated
   a_bad_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_setting |->
         (rsp_data.sysclk_hz == '0) || (rsp_data.sysclk_hz == '1))
      else $error("bad_setting with unexpected sysclk");

   // prescalers only divide down
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ahb_hz <= rsp_data.sysclk_hz)
         && (rsp_data.apb1_timer_hz <= rsp_data.ahb_hz)
         && (rsp_data.apb2_timer_hz <= rsp_data.ahb_hz))
      else $error("bus clock above its parent");

   // bus clock equals timer clock or half of it
   a_apb1_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.apb1_hz == rsp_data.apb1_timer_hz)
         || (rsp_data.apb1_hz == (rsp_data.apb1_timer_hz >> 1)))
      else $error("apb1 bus/timer mismatch");

   a_apb2_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.apb2_hz == rsp_data.apb2_timer_hz)
         || (rsp_data.apb2_hz == (rsp_data.apb2_timer_hz >> 1)))
      else $error("apb2 bus/timer mismatch");

endmodule

// ===== hdl/ctfc_front.sv =====
// Front end: takes requests, holds the oscillator register, classifies each request.
module ctfc_front import ctfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  logic              csr_wr_en,
   input  logic [BASE_W-1:0] csr_wr_data,
   output logic              push_valid,
   output cls_type           push_data,
   input  logic              queue_full
);

   logic [BASE_W-1:0] hse_ff, hse_in;
   logic              valid_ff, valid_in;
   cls_type           item_ff, item_in;
   cls_type           cls;
   logic              accept;

   always_comb begin
      cls = '0;
      cls.m      = req_data.pll_m;
      cls.n      = req_data.pll_n;
      cls.p_code = req_data.pll_p_code;
      cls.base_hz = req_data.pll_source ? hse_ff : HSI_HZ;
      unique case (req_data.clock_source)
         SRC_INTERNAL: cls.fixed_hz = HSI_HZ;
         SRC_EXTERNAL: cls.fixed_hz = hse_ff;
         SRC_PLL:      cls.fixed_hz = '0;
         SRC_INVALID:  cls.fixed_hz = '0;
         default:      cls.fixed_hz = '0;
      endcase
      cls.is_pll = (req_data.clock_source == SRC_PLL);
      cls.bad_m  = cls.is_pll && (req_data.pll_m == '0);
      // AHB: 8..11 -> 1..4, 12..15 -> 6..9
      if (req_data.ahb_code[3]) begin
         if (req_data.ahb_code[2]) begin
            cls.ahb_sh = {1'b0, req_data.ahb_code[2:0]} + 4'd2;
         end else begin
            cls.ahb_sh = {1'b0, req_data.ahb_code[2:0]} + 4'd1;
         end
      end else begin
         cls.ahb_sh = '0;
      end
      cls.apb1_bus_sh = req_data.apb1_code[2] ? {1'b0, req_data.apb1_code[1:0]} + 3'd1 : '0;
      cls.apb1_tmr_sh = req_data.apb1_code[2] ? req_data.apb1_code[1:0] : '0;
      cls.apb2_bus_sh = req_data.apb2_code[2] ? {1'b0, req_data.apb2_code[1:0]} + 3'd1 : '0;
      cls.apb2_tmr_sh = req_data.apb2_code[2] ? req_data.apb2_code[1:0] : '0;
   end

   assign push_valid = valid_ff;
   assign push_data  = item_ff;
   assign req_stall  = valid_ff && queue_full;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      hse_in   = csr_wr_en ? csr_wr_data : hse_ff;
      item_in  = accept ? cls : item_ff;
      valid_in = accept || (valid_ff && queue_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hse_ff   <= HSE_RESET;
         valid_ff <= 1'b0;
      end else begin
         hse_ff   <= hse_in;
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== hdl/ctfc_queue.sv =====
// Small queue of classified requests between front and back.
module ctfc_queue import ctfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cls_type push_data,
   output logic    full,
   output logic    pop_valid,
   output cls_type pop_data,
   input  logic    pop_en
);

   cls_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_en && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/ctfc_back.sv =====
// Back end: pipelined PLL arithmetic, saturation and bus prescalers.
module ctfc_back import ctfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cls_type in_data,
   output logic    in_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      cls_type             c;
      logic [M_W-1:0]      rem_m;
      logic [BASE_W-1:0]   dvd_m;
      logic [BASE_W-1:0]   quo_m;
      logic [PROD_W-1:0]   prod;
      logic [SCALED_W-1:0] scaled;
      logic [PP_W-1:0]     pp_lo;
      logic [PP_W-1:0]     pp_hi;
      logic [SCALED_W-1:0] quo3;
      logic [HZ_W-1:0]     sys;
      logic [HZ_W-1:0]     ahb;
      logic                bad;
   } work_type;

   work_type pipe_ff [NUM_STAGES];
   work_type pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    advance;

   // whole pipeline holds while a finished response is stalled
   assign advance   = !(out_valid_ff && rsp_stall);
   assign in_pop    = advance && in_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      pipe_in[0]       = '0;
      pipe_in[0].c     = in_data;
      pipe_in[0].dvd_m = in_data.base_hz;
   end

   for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stage
      if (g <= M_DIV_STAGES) begin : g_mdiv
         // restoring divide of base by M, M_STEPS quotient bits per stage
         always_comb begin
            work_type     w;
            logic [M_W:0] r;
            logic         qbit;
            w = pipe_ff[g-1];
            for (int k = 0; k < M_STEPS; k++) begin
               if ((g - 1) * M_STEPS + k < BASE_W) begin
                  r    = {w.rem_m, w.dvd_m[BASE_W-1]};
                  w.dvd_m = {w.dvd_m[BASE_W-2:0], 1'b0};
                  qbit = (r >= {1'b0, w.c.m});
                  if (qbit) begin
                     w.rem_m = M_W'(r - {1'b0, w.c.m});
                  end else begin
                     w.rem_m = r[M_W-1:0];
                  end
                  w.quo_m = {w.quo_m[BASE_W-2:0], qbit};
               end
            end
            pipe_in[g] = w;
         end
      end else if (g == MUL_IDX) begin : g_mul
         always_comb begin
            pipe_in[g]      = pipe_ff[g-1];
            pipe_in[g].prod = {{N_W{1'b0}}, pipe_ff[g-1].quo_m}
                              * {{BASE_W{1'b0}}, pipe_ff[g-1].c.n};
         end
      end else if (g == SHIFT_IDX) begin : g_pshift
         // powers of two of P; the factor 3 of P=6 follows
         always_comb begin
            work_type w;
            w = pipe_ff[g-1];
            case (w.c.p_code)
               P_DIV2:  w.scaled = SCALED_W'(w.prod >> 1);
               P_DIV4:  w.scaled = SCALED_W'(w.prod >> 2);
               P_DIV6:  w.scaled = SCALED_W'(w.prod >> 1);
               P_DIV8:  w.scaled = SCALED_W'(w.prod >> 3);
               default: w.scaled = SCALED_W'(w.prod >> 1);
            endcase
            pipe_in[g] = w;
         end
      end else if (g == DIV3_MUL_IDX) begin : g_div3_mul
         // reciprocal of 3 times each half of the scaled value
         always_comb begin
            pipe_in[g]       = pipe_ff[g-1];
            pipe_in[g].pp_lo = PP_W'(pipe_ff[g-1].scaled[DIV3_SPLIT-1:0]) * PP_W'(RECIP3);
            pipe_in[g].pp_hi = PP_W'(pipe_ff[g-1].scaled[SCALED_W-1:DIV3_SPLIT])
                               * PP_W'(RECIP3);
         end
      end else if (g == DIV3_SUM_IDX) begin : g_div3_sum
         always_comb begin
            work_type               w;
            logic [DIV3_PROD_W-1:0] prod3;
            w      = pipe_ff[g-1];
            prod3  = {w.pp_hi, {DIV3_SPLIT{1'b0}}} + DIV3_PROD_W'(w.pp_lo);
            w.quo3 = SCALED_W'(prod3 >> RECIP3_SH);
            pipe_in[g] = w;
         end
      end else begin : g_sys
         always_comb begin
            work_type            w;
            logic [SCALED_W-1:0] val;
            w   = pipe_ff[g-1];
            val = (w.c.p_code == P_DIV6) ? w.quo3 : w.scaled;
            if (w.c.is_pll) begin
               if (w.c.bad_m) begin
                  w.sys = '0;
                  w.bad = 1'b1;
               end else if (val[SCALED_W-1:HZ_W] != '0) begin
                  w.sys = '1;
                  w.bad = 1'b1;
               end else begin
                  w.sys = val[HZ_W-1:0];
                  w.bad = 1'b0;
               end
            end else begin
               w.sys = {{(HZ_W-BASE_W){1'b0}}, w.c.fixed_hz};
               w.bad = 1'b0;
            end
            w.ahb = w.sys >> w.c.ahb_sh;
            pipe_in[g] = w;
         end
      end
   end

   always_comb begin
      work_type w;
      w = pipe_ff[NUM_STAGES-1];
      out_in.sysclk_hz     = w.sys;
      out_in.ahb_hz        = w.ahb;
      out_in.apb1_hz       = w.ahb >> w.c.apb1_bus_sh;
      out_in.apb1_timer_hz = w.ahb >> w.c.apb1_tmr_sh;
      out_in.apb2_hz       = w.ahb >> w.c.apb2_bus_sh;
      out_in.apb2_timer_hz = w.ahb >> w.c.apb2_tmr_sh;
      out_in.bad_setting   = w.bad;
      vld_in       = {vld_ff[NUM_STAGES-2:0], in_valid};
      out_valid_in = vld_ff[NUM_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         out_ff <= out_in;
      end
   end

endmodule

// ===== bench/clock_tree_frequency_calc_top_tb.sv =====
// Self-checking testbench for the clock tree frequency calculator top level.
`timescale 1ns / 1ps

module clock_tree_frequency_calc_top_tb;
   import ctfc_pkg::*;

   // Run length guard: about 650 requests, plus reset, pipeline drain and idle
   // pauses, taken many times over.
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned IDLE_PCT     = 35;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam logic [BASE_W-1:0] HSE_MAX = BASE_W'(50000000);

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [BASE_W-1:0] csr_wr_data;

   // Requests waiting to be driven, and the clock sets they must produce.
   req_type           pending_requests[$];
   rsp_type           expected_clocks[$];

   // Local copy of the oscillator register, updated when it is written.
   logic [BASE_W-1:0] hse_hz;

   bit                req_taken;      // request accepted at the last rising edge
   bit                calm;           // no idling on either side while set
   int unsigned       failure_count;
   rsp_type           want;

   clock_tree_frequency_calc_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // APB prescaler: codes 4..7 divide the bus clock by 2..16 and the
   // timer clock by 1..8; lower codes pass the AHB clock through.
   function automatic int unsigned apb_shift(logic [2:0] code, bit timer);
      if (!code[2])
         return 0;
      return timer ? int'(code[1:0]) : int'(code[1:0]) + 1;
   endfunction

   function automatic rsp_type predict_clocks(req_type r, logic [BASE_W-1:0] hse);
      rsp_type     o;
      logic [63:0] base;
      logic [63:0] pll_out;
      logic [31:0] sys;
      logic [31:0] ahb;
      int unsigned ahb_sh;
      o   = '0;
      sys = '0;
      case (r.clock_source)
         SRC_INTERNAL: sys = 32'(HSI_HZ);
         SRC_EXTERNAL: sys = 32'(hse);
         SRC_PLL: begin
            if (r.pll_m == '0) begin
               // zero pre-divider: everything reads zero, flagged
               o.bad_setting = 1'b1;
            end else begin
               base    = r.pll_source ? 64'(hse) : 64'(HSI_HZ);
               // truncating divide by M first, exact product, then /P
               pll_out = ((base / 64'(r.pll_m)) * 64'(r.pll_n))
                         / (64'(r.pll_p_code) * 2 + 2);
               if (pll_out > 64'hFFFF_FFFF) begin
                  sys           = 32'hFFFF_FFFF;
                  o.bad_setting = 1'b1;
               end else begin
                  sys = pll_out[31:0];
               end
            end
         end
         default: sys = '0;   // invalid switch status
      endcase
      // AHB codes 8..11 shift by 1..4, codes 12..15 by 6..9
      if (!r.ahb_code[3])
         ahb_sh = 0;
      else if (r.ahb_code[2])
         ahb_sh = int'(r.ahb_code[2:0]) + 2;
      else
         ahb_sh = int'(r.ahb_code[2:0]) + 1;
      ahb             = sys >> ahb_sh;
      o.sysclk_hz     = sys;
      o.ahb_hz        = ahb;
      o.apb1_hz       = ahb >> apb_shift(r.apb1_code, 1'b0);
      o.apb1_timer_hz = ahb >> apb_shift(r.apb1_code, 1'b1);
      o.apb2_hz       = ahb >> apb_shift(r.apb2_code, 1'b0);
      o.apb2_timer_hz = ahb >> apb_shift(r.apb2_code, 1'b1);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type make_snapshot(logic [1:0] src, logic psrc, int m, int n,
                                             logic [1:0] p, int ahb, int apb1, int apb2);
      req_type r;
      r.clock_source = src;
      r.pll_source   = psrc;
      r.pll_m        = M_W'(m);
      r.pll_n        = N_W'(n);
      r.pll_p_code   = p;
      r.ahb_code     = 4'(ahb);
      r.apb1_code    = 3'(apb1);
      r.apb2_code    = 3'(apb2);
      return r;
   endfunction

   // Biased toward the PLL path, with extra weight on M of zero and on
   // small M values, where the product can saturate.
   function automatic req_type random_snapshot();
      req_type     r;
      int unsigned pick;
      r.clock_source = ($urandom_range(99) < 55) ? SRC_PLL : 2'($urandom_range(3));
      r.pll_source   = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 8)
         r.pll_m = '0;
      else if (pick < 28)
         r.pll_m = M_W'($urandom_range(3, 1));
      else
         r.pll_m = M_W'($urandom_range(63));
      r.pll_n      = N_W'($urandom_range(511));
      r.pll_p_code = 2'($urandom_range(3));
      r.ahb_code   = 4'($urandom_range(15));
      r.apb1_code  = 3'($urandom_range(7));
      r.apb2_code  = 3'($urandom_range(7));
      return r;
   endfunction

   task automatic queue_random(int unsigned count);
      @(posedge clock);
      repeat (count) pending_requests.push_back(random_snapshot());
   endtask

   // Block until every request is sent and every response is back.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_clocks.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hse(logic [BASE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      hse_hz       = value;
   endtask

   // ------------------------------------------------------------------
   // Request driver: changes only at the falling edge. A held request
   // stays put until it is taken; after that the next one is drawn, or
   // the channel idles.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure, random except in the calm phase.
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
      failure_count++;
      if (failure_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
   endtask

   // ------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. The response is
   // checked before the new expectation is queued, so a stray response
   // cannot be matched against a request taken in the same cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_clocks.size() == 0) begin
            failure_count++;
            if (failure_count <= MAX_REPORTS)
               $display("response with no request pending: sysclk %0d", rsp_data.sysclk_hz);
         end else begin
            want = expected_clocks.pop_front();
            if (rsp_data.sysclk_hz !== want.sysclk_hz)
               note_mismatch("sysclk_hz", want.sysclk_hz, rsp_data.sysclk_hz);
            if (rsp_data.ahb_hz !== want.ahb_hz)
               note_mismatch("ahb_hz", want.ahb_hz, rsp_data.ahb_hz);
            if (rsp_data.apb1_hz !== want.apb1_hz)
               note_mismatch("apb1_hz", want.apb1_hz, rsp_data.apb1_hz);
            if (rsp_data.apb1_timer_hz !== want.apb1_timer_hz)
               note_mismatch("apb1_timer_hz", want.apb1_timer_hz, rsp_data.apb1_timer_hz);
            if (rsp_data.apb2_hz !== want.apb2_hz)
               note_mismatch("apb2_hz", want.apb2_hz, rsp_data.apb2_hz);
            if (rsp_data.apb2_timer_hz !== want.apb2_timer_hz)
               note_mismatch("apb2_timer_hz", want.apb2_timer_hz, rsp_data.apb2_timer_hz);
            if (rsp_data.bad_setting !== want.bad_setting)
               note_mismatch("bad_setting", 32'(want.bad_setting), 32'(rsp_data.bad_setting));
         end
      end
      if (req_taken)
         expected_clocks.push_back(predict_clocks(req_data, hse_hz));
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("clock_tree_frequency_calc_top_tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      calm          = 1'b0;
      failure_count = 0;
      hse_hz        = HSE_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests against the reset oscillator value (25 MHz).
      @(posedge clock);
      // fixed sources with the prescaler extremes; PLL fields ignored
      pending_requests.push_back(make_snapshot(SRC_INTERNAL, 0, 0, 0, P_DIV2, 0, 0, 0));
      pending_requests.push_back(make_snapshot(SRC_INTERNAL, 1, 63, 511, P_DIV8, 15, 7, 7));
      pending_requests.push_back(make_snapshot(SRC_EXTERNAL, 0, 0, 0, P_DIV2, 8, 4, 4));
      pending_requests.push_back(make_snapshot(SRC_EXTERNAL, 1, 63, 511, P_DIV8, 7, 3, 3));
      // invalid switch status reads zero, not flagged
      pending_requests.push_back(make_snapshot(SRC_INVALID, 1, 8, 336, P_DIV4, 0, 0, 0));
      pending_requests.push_back(make_snapshot(SRC_INVALID, 0, 0, 0, P_DIV2, 15, 7, 7));
      // PLL with zero pre-divider
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 0, 336, P_DIV2, 0, 0, 0));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 0, 511, P_DIV8, 8, 5, 6));
      // PLL with zero multiplier
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 8, 0, P_DIV2, 0, 0, 0));
      // saturation, and values just either side of it
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 1, 511, P_DIV2, 0, 0, 0));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 1, 511, P_DIV8, 0, 0, 0));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 1, 344, P_DIV2, 13, 1, 2));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 1, 343, P_DIV2, 14, 2, 3));
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 1, 511, P_DIV2, 12, 0, 0));
      // ordinary PLL settings over every P code and prescaler range
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 8, 336, P_DIV4, 0, 5, 4));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 25, 336, P_DIV2, 9, 6, 7));
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 16, 432, P_DIV6, 10, 4, 5));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 63, 1, P_DIV8, 11, 7, 4));
      // truncating divide by M
      pending_requests.push_back(make_snapshot(SRC_PLL, 0, 3, 255, P_DIV6, 15, 6, 6));
      pending_requests.push_back(make_snapshot(SRC_PLL, 1, 7, 100, P_DIV4, 8, 7, 0));

      // Top of the oscillator range: PLL settings with small M saturate from it.
      wait_idle();
      write_hse(HSE_MAX);
      queue_random(150);

      // Oscillator stopped.
      wait_idle();
      write_hse('0);
      queue_random(80);

      // Random oscillator, both sides streaming with no idling.
      wait_idle();
      write_hse(BASE_W'($urandom_range(50000000)));
      calm = 1'b1;
      queue_random(150);

      wait_idle();
      calm = 1'b0;
      write_hse(BASE_W'($urandom_range(50000000)));
      queue_random(150);

      wait_idle();
      write_hse(BASE_W'($urandom_range(50000000)));
      queue_random(100);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && expected_clocks.size() == 0) begin
         $display("clock_tree_frequency_calc_top_tb OK");
      end else begin
         $display("clock_tree_frequency_calc_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ctfc_pkg.sv
hdl/ctfc_front.sv
hdl/ctfc_queue.sv
hdl/ctfc_back.sv
hdl/clock_tree_frequency_calc_top.sv
bench/clock_tree_frequency_calc_top_tb.sv
